/* hw/rtl/lpmt_pkg.sv */
package lpmt_pkg;

	// Operation codes carried on the opcode field.
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Completion codes for an add request.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_CONFLICT = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// One stored listener.
	typedef struct packed {
		logic [31:0] address;
		logic [15:0] port;
		logic        kind;
		logic [31:0] context_tag;
	} entry_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

endpackage

/* hw/rtl/listener_port_match_table.sv */
// Listener port match table.
// Input channel (in_valid/in_ready) carries one request: an add of a listener
// (opcode 0) or a lookup of a destination (opcode 1). Output channel
// (out_valid/out_ready) returns exactly one response per request, in order.
// Entries are kept in a single-port synchronous memory and filled from slot 0
// upward; they are never removed, so a fill count marks the live entries.
// A request reads the live entries one per cycle, compares each as its read
// data returns, then writes the new entry (add, status ok) and loads the
// output register. The scan is bounded by the one read port of the entry
// memory: its length grows with the number of live entries, and an empty
// table skips the scan. Requests are processed one at a time: the next one
// is accepted the cycle after a response loads.
// The output register lets a new request be accepted while the previous
// response still waits; if the receiver stalls, the finished response of the
// next request holds in the block until the register frees up.
// Reset (arst_n low) empties the table at once: the fill count clears and no
// memory sweep is needed. The response channel is idle after reset.
module listener_port_match_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] local_address,
	input  logic [15:0] port_number,
	input  logic        handler_present,
	input  logic        handler_kind,
	input  logic [31:0] context_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic        matched_wildcard,
	output logic        found_kind,
	output logic [31:0] found_context
);
	import lpmt_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

	state_t state_q, state_d;

	// Latched request.
	logic        op_q;
	logic [31:0] addr_q;
	logic [15:0] port_q;
	logic        present_q;
	logic        kind_q;
	logic [31:0] ctx_q;

	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] idx_q;

	// Entry memory and its registered read port.
	entry_t mem [TABLE_ENTRIES];
	entry_t rd_data_s1;
	logic   rd_vld_s1;

	// Scan results.
	logic        conflict_q;
	logic        exact_hit_q;
	logic        wild_hit_q;
	logic        exact_kind_q;
	logic [31:0] exact_ctx_q;
	logic        wild_kind_q;
	logic [31:0] wild_ctx_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        found_q;
	logic        wild_q;
	logic        fkind_q;
	logic [31:0] fctx_q;

	logic in_accept;
	logic rd_en;
	logic last_issue;
	logic finish;
	logic out_free;
	logic add_ok;
	logic [1:0] add_status;

	logic port_eq;
	logic exact_eq;
	logic wild_eq;

	assign in_accept  = in_valid && in_ready;
	assign last_issue = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	assign out_free   = !out_valid_q || out_ready;

	// Compare the entry whose read data has just returned.
	assign port_eq  = rd_vld_s1 && (rd_data_s1.port == port_q);
	assign exact_eq = port_eq && (rd_data_s1.address == addr_q);
	assign wild_eq  = port_eq && (rd_data_s1.address == 32'd0);

	// Add outcome once every live entry has been compared.
	always_comb begin
		if ((port_q == 16'd0) || !present_q) begin
			add_status = ST_INVALID;
		end else if (conflict_q) begin
			add_status = ST_CONFLICT;
		end else if (cnt_q == CNT_FULL) begin
			add_status = ST_FULL;
		end else begin
			add_status = ST_OK;
		end
	end
	assign add_ok = (op_q == OP_ADD) && (add_status == ST_OK);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		finish   = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (cnt_q == '0) ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				rd_en = 1'b1;
				if (last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q      <= opcode;
			addr_q    <= local_address;
			port_q    <= port_number;
			present_q <= handler_present;
			kind_q    <= handler_kind;
			ctx_q     <= context_tag;
		end
	end

	// Scan index and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (in_accept) begin
				idx_q <= '0;
			end else if (rd_en && !last_issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (finish && add_ok) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Entry memory: one read or one write per cycle.
	always_ff @(posedge clk) begin
		if (finish && add_ok) begin
			mem[cnt_q[IDX_W-1:0]] <= '{address: addr_q, port: port_q, kind: kind_q,
				context_tag: ctx_q};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	// Accumulate conflicts and the first exact and wildcard matches.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			conflict_q  <= 1'b0;
			exact_hit_q <= 1'b0;
			wild_hit_q  <= 1'b0;
		end else begin
			if (port_eq && (exact_eq || wild_eq || (addr_q == 32'd0))) begin
				conflict_q <= 1'b1;
			end
			if (exact_eq && !exact_hit_q) begin
				exact_hit_q  <= 1'b1;
				exact_kind_q <= rd_data_s1.kind;
				exact_ctx_q  <= rd_data_s1.context_tag;
			end
			if (wild_eq && !exact_eq && !wild_hit_q) begin
				wild_hit_q  <= 1'b1;
				wild_kind_q <= rd_data_s1.kind;
				wild_ctx_q  <= rd_data_s1.context_tag;
			end
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (finish) begin
			if (op_q == OP_ADD) begin
				status_q <= add_status;
				found_q  <= 1'b0;
				wild_q   <= 1'b0;
				fkind_q  <= 1'b0;
				fctx_q   <= 32'd0;
			end else if (exact_hit_q) begin
				status_q <= ST_OK;
				found_q  <= 1'b1;
				wild_q   <= (addr_q == 32'd0);
				fkind_q  <= exact_kind_q;
				fctx_q   <= exact_ctx_q;
			end else if (wild_hit_q) begin
				status_q <= ST_OK;
				found_q  <= 1'b1;
				wild_q   <= 1'b1;
				fkind_q  <= wild_kind_q;
				fctx_q   <= wild_ctx_q;
			end else begin
				status_q <= ST_OK;
				found_q  <= 1'b0;
				wild_q   <= 1'b0;
				fkind_q  <= 1'b0;
				fctx_q   <= 32'd0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign found            = found_q;
	assign matched_wildcard = wild_q;
	assign found_kind       = fkind_q;
	assign found_context    = fctx_q;

endmodule
